### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LPI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPI_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPI_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPI_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### design/lpi_pkg.sv
// ----------------------------------------------------------------------------
// lpi_pkg
// Types and codes shared by the line/plane intersection pipeline.
// ----------------------------------------------------------------------------
package lpi_pkg;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_NONE     = 2'd0;
    localparam t_kind KIND_IN_SEG   = 2'd1;
    localparam t_kind KIND_OUT_SEG  = 2'd2;
    localparam t_kind KIND_IN_PLANE = 2'd3;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx REG_PLANE_X  = 3'd0;
    localparam t_cfg_idx REG_PLANE_Y  = 3'd1;
    localparam t_cfg_idx REG_PLANE_Z  = 3'd2;
    localparam t_cfg_idx REG_NORMAL_X = 3'd3;
    localparam t_cfg_idx REG_NORMAL_Y = 3'd4;
    localparam t_cfg_idx REG_NORMAL_Z = 3'd5;
    localparam t_cfg_idx REG_EPSILON  = 3'd6;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_line;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] t_value;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic               saturated;
    } t_result;

    typedef struct packed {
        logic signed [31:0] plane_x;
        logic signed [31:0] plane_y;
        logic signed [31:0] plane_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic [30:0]        epsilon;
    } t_plane;

    typedef struct packed {
        logic signed [63:0] dn;
        logic signed [63:0] sd;
        t_line              line;
    } t_dot;

    typedef struct packed {
        logic [31:0] quo;
        logic        big;
        logic        neg;
        logic        par;
        logic        on_plane;
        t_line       line;
    } t_quot;

endpackage

### design/lpi_dot.sv
// ----------------------------------------------------------------------------
// lpi_dot
// Two stages: nine products, then N.D and signed distance N.O - N.P.
// ----------------------------------------------------------------------------
module lpi_dot
    import lpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_line  i_line,
    input  t_plane i_plane,
    output logic   o_valid,
    output t_dot   o_dot
);

    logic signed [63:0] n_nd0, n_nd1, n_nd2, n_no0, n_no1, n_no2, n_np0, n_np1, n_np2;
    logic signed [63:0] r_nd0, r_nd1, r_nd2, r_no0, r_no1, r_no2, r_np0, r_np1, r_np2;
    t_line              r_line;
    logic               r_v1;
    t_dot               n_dot, r_dot;
    logic               r_v2;

    always_comb begin
        n_nd0 = i_plane.normal_x * i_line.dir_x;
        n_nd1 = i_plane.normal_y * i_line.dir_y;
        n_nd2 = i_plane.normal_z * i_line.dir_z;
        n_no0 = i_plane.normal_x * i_line.origin_x;
        n_no1 = i_plane.normal_y * i_line.origin_y;
        n_no2 = i_plane.normal_z * i_line.origin_z;
        n_np0 = i_plane.normal_x * i_plane.plane_x;
        n_np1 = i_plane.normal_y * i_plane.plane_y;
        n_np2 = i_plane.normal_z * i_plane.plane_z;
    end

    // floor shift of each product, then sum
    always_comb begin
        n_dot.dn   = (r_nd0 >>> FRAC_BITS) + (r_nd1 >>> FRAC_BITS) + (r_nd2 >>> FRAC_BITS);
        n_dot.sd   = (r_no0 >>> FRAC_BITS) + (r_no1 >>> FRAC_BITS) + (r_no2 >>> FRAC_BITS)
                   - (r_np0 >>> FRAC_BITS) - (r_np1 >>> FRAC_BITS) - (r_np2 >>> FRAC_BITS);
        n_dot.line = r_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nd0  <= n_nd0;
            r_nd1  <= n_nd1;
            r_nd2  <= n_nd2;
            r_no0  <= n_no0;
            r_no1  <= n_no1;
            r_no2  <= n_no2;
            r_np0  <= n_np0;
            r_np1  <= n_np1;
            r_np2  <= n_np2;
            r_line <= i_line;
            r_dot  <= n_dot;
        end
    end

    assign o_valid = r_v2;
    assign o_dot   = r_dot;

endmodule

### design/lpi_div.sv
// ----------------------------------------------------------------------------
// lpi_div
// Magnitude setup and a restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lpi_div
    import lpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_dot        i_dot,
    input  logic [30:0] i_eps,
    output logic        o_valid,
    output t_quot       o_quot
);

    localparam int STEPS = 32;

    typedef struct packed {
        logic [64:0] rem;
        logic [63:0] den;
        logic [31:0] lo;
        logic [31:0] quo;
        logic        big;
        logic        neg;
        logic        par;
        logic        on_plane;
        t_line       line;
    } t_div_stage;

    t_div_stage  n_stg [STEPS+1];
    t_div_stage  r_stg [STEPS+1];
    logic        r_vld [STEPS+1];
    logic [63:0] n_a, n_b;

    // quotient below 2^32 iff the top part of |sd| << FRAC_BITS is below |dn|
    always_comb begin
        n_a = i_dot.sd[63] ? 64'(-i_dot.sd) : 64'(i_dot.sd);
        n_b = i_dot.dn[63] ? 64'(-i_dot.dn) : 64'(i_dot.dn);
        n_stg[0].rem      = 65'(n_a >> (32 - FRAC_BITS));
        n_stg[0].den      = n_b;
        n_stg[0].lo       = {n_a[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        n_stg[0].quo      = '0;
        n_stg[0].big      = n_stg[0].rem >= {1'b0, n_b};
        n_stg[0].neg      = (i_dot.sd[63] == i_dot.dn[63]) && (i_dot.sd != '0);
        n_stg[0].par      = n_b <= 64'(i_eps);
        n_stg[0].on_plane = n_a <= 64'(i_eps);
        n_stg[0].line     = i_dot.line;
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [64:0] w_rem;
        always_comb begin
            n_stg[k+1] = r_stg[k];
            w_rem      = {r_stg[k].rem[63:0], r_stg[k].lo[31]};
            n_stg[k+1].lo = {r_stg[k].lo[30:0], 1'b0};
            if (w_rem >= {1'b0, r_stg[k].den}) begin
                n_stg[k+1].rem = w_rem - {1'b0, r_stg[k].den};
                n_stg[k+1].quo = {r_stg[k].quo[30:0], 1'b1};
            end else begin
                n_stg[k+1].rem = w_rem;
                n_stg[k+1].quo = {r_stg[k].quo[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STEPS; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < STEPS; k++) r_vld[k+1] <= r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= STEPS; k++) r_stg[k] <= n_stg[k];
        end
    end

    always_comb begin
        o_quot.quo      = r_stg[STEPS].quo;
        o_quot.big      = r_stg[STEPS].big;
        o_quot.neg      = r_stg[STEPS].neg;
        o_quot.par      = r_stg[STEPS].par;
        o_quot.on_plane = r_stg[STEPS].on_plane;
        o_quot.line     = r_stg[STEPS].line;
    end

    assign o_valid = r_vld[STEPS];

endmodule

### design/lpi_hit.sv
// ----------------------------------------------------------------------------
// lpi_hit
// Signed clamped t, products D*t, hit point with clamping, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpi_hit
    import lpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_quot   i_quot,
    output logic    o_valid,
    output t_result o_result
);

    localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] S32MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32MIN = 32'sh8000_0000;

    logic signed [31:0] n_t, r_t;
    logic               n_sat, r_sat, r_par, r_onp;
    t_line              r_line;
    logic               r_v1;

    logic signed [63:0] n_px, n_py, n_pz, r_px, r_py, r_pz;
    t_kind              n_kind, r_kind;
    logic signed [31:0] r_t2;
    logic               r_sat2, r_par2;
    t_line              r_line2;
    logic               r_v2;

    logic signed [63:0] n_hx, n_hy, n_hz;
    t_result            n_res, r_res;
    logic               r_valid;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        logic over;
        logic under;
        over  = !v[63] && (|v[62:31]);
        under = v[63] && !(&v[62:31]);
        if (over) begin
            clamp32 = S32MAX;
        end else if (under) begin
            clamp32 = S32MIN;
        end else begin
            clamp32 = v[31:0];
        end
    endfunction

    function automatic logic oor32(input logic signed [63:0] v);
        oor32 = (!v[63] && (|v[62:31])) || (v[63] && !(&v[62:31]));
    endfunction

    always_comb begin
        n_t   = '0;
        n_sat = 1'b0;
        if (!i_quot.par) begin
            if (i_quot.neg) begin
                if (i_quot.big || (i_quot.quo[31] && (|i_quot.quo[30:0]))) begin
                    n_t   = S32MIN;
                    n_sat = 1'b1;
                end else begin
                    n_t = -$signed(i_quot.quo);
                end
            end else begin
                if (i_quot.big || i_quot.quo[31]) begin
                    n_t   = S32MAX;
                    n_sat = 1'b1;
                end else begin
                    n_t = $signed(i_quot.quo);
                end
            end
        end
    end

    always_comb begin
        n_px = r_line.dir_x * r_t;
        n_py = r_line.dir_y * r_t;
        n_pz = r_line.dir_z * r_t;
        if (r_par) begin
            n_kind = r_onp ? KIND_IN_PLANE : KIND_NONE;
        end else if (r_t >= 0 && r_t <= ONE_FX) begin
            n_kind = KIND_IN_SEG;
        end else begin
            n_kind = KIND_OUT_SEG;
        end
    end

    always_comb begin
        n_hx = r_line2.origin_x + (r_px >>> FRAC_BITS);
        n_hy = r_line2.origin_y + (r_py >>> FRAC_BITS);
        n_hz = r_line2.origin_z + (r_pz >>> FRAC_BITS);
        n_res.kind      = r_kind;
        n_res.t_value   = r_t2;
        if (r_par2) begin
            n_res.hit_x     = '0;
            n_res.hit_y     = '0;
            n_res.hit_z     = '0;
            n_res.saturated = 1'b0;
        end else begin
            n_res.hit_x     = clamp32(n_hx);
            n_res.hit_y     = clamp32(n_hy);
            n_res.hit_z     = clamp32(n_hz);
            n_res.saturated = r_sat2 || oor32(n_hx) || oor32(n_hy) || oor32(n_hz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= n_t;
            r_sat   <= n_sat;
            r_par   <= i_quot.par;
            r_onp   <= i_quot.on_plane;
            r_line  <= i_quot.line;
            r_px    <= n_px;
            r_py    <= n_py;
            r_pz    <= n_pz;
            r_kind  <= n_kind;
            r_t2    <= r_t;
            r_sat2  <= r_sat;
            r_par2  <= r_par;
            r_line2 <= r_line;
            r_res   <= n_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    `LPI_ASSERT(a_parallel_zero, i_clk, i_rst_n,
        r_valid && (r_res.kind == KIND_NONE || r_res.kind == KIND_IN_PLANE) |->
            r_res.t_value == '0 && r_res.hit_x == '0 && r_res.hit_y == '0 &&
            r_res.hit_z == '0 && !r_res.saturated,
        "parallel result not zero")
    `LPI_ASSERT(a_in_seg_range, i_clk, i_rst_n,
        r_valid && r_res.kind == KIND_IN_SEG |-> r_res.t_value >= 0 && r_res.t_value <= ONE_FX,
        "in-segment kind with t outside unit range")
    `LPI_ASSERT_NR(a_reset_clears, i_clk, !i_rst_n |=> !r_valid, "result valid right after reset")

endmodule

### design/line_plane_intersection.sv
// ----------------------------------------------------------------------------
// line_plane_intersection
// Parametric line against a configured plane, signed fixed point.
// ----------------------------------------------------------------------------
// channel   direction  handshake               word
// line      in         i_valid / o_stall       t_line (origin, direction)
// result    out        o_valid / i_stall       t_result
// config    in         i_cfg_valid / o_cfg_ready  index + 32-bit data
//
// One line per cycle sustained while the result is not stalled; 2 dot-product
// stages, 1 setup stage, 32 divider stages (one quotient bit each), 3 hit stages.
// A stalled result freezes the whole pipeline; o_stall = o_valid & i_stall.
// Synchronous active-low reset clears valid bits and loads register defaults.
// Config port is always ready.
// ----------------------------------------------------------------------------
module line_plane_intersection
    import lpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_line    i_line,
    output logic     o_valid,
    input  logic     i_stall,
    output t_result  o_result,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  t_cfg_idx i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [31:0] ONE_FX = 32'h1 << FRAC_BITS;

    t_plane r_plane;
    logic   w_en;
    logic   w_dot_valid, w_quot_valid;
    t_dot   w_dot;
    t_quot  w_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane.plane_x  <= '0;
            r_plane.plane_y  <= '0;
            r_plane.plane_z  <= '0;
            r_plane.normal_x <= '0;
            r_plane.normal_y <= '0;
            r_plane.normal_z <= ONE_FX;
            r_plane.epsilon  <= 31'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PLANE_X:  r_plane.plane_x  <= i_cfg_data;
                REG_PLANE_Y:  r_plane.plane_y  <= i_cfg_data;
                REG_PLANE_Z:  r_plane.plane_z  <= i_cfg_data;
                REG_NORMAL_X: r_plane.normal_x <= i_cfg_data;
                REG_NORMAL_Y: r_plane.normal_y <= i_cfg_data;
                REG_NORMAL_Z: r_plane.normal_z <= i_cfg_data;
                REG_EPSILON:  r_plane.epsilon  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_en        = !o_valid || !i_stall;
    assign o_stall     = !w_en;

    lpi_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_line  (i_line),
        .i_plane (r_plane),
        .o_valid (w_dot_valid),
        .o_dot   (w_dot)
    );

    lpi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dot_valid),
        .i_dot   (w_dot),
        .i_eps   (r_plane.epsilon),
        .o_valid (w_quot_valid),
        .o_quot  (w_quot)
    );

    lpi_hit #(.FRAC_BITS(FRAC_BITS)) u_hit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_quot_valid),
        .i_quot   (w_quot),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
